FILE: design/srt_pkg.sv
// Shared types and constants for the sorted record table.
// No dependencies; used by the table unit, by the checker and by the testbench.
`default_nettype none

package srt_pkg;

    // Field widths
    localparam int KEY_W   = 16;
    localparam int SCORE_W = 7;
    localparam int SUM_W   = 8;

    // Default table depth
    localparam int SRT_DEPTH = 32;

    // Stream widths (byte padded)
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 3;

    // One stored record; key sits in the low bits
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [SCORE_W-1:0] second;
        logic [SCORE_W-1:0] first;
        logic [KEY_W-1:0]   key;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LIST   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_LISTED   = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

endpackage

`default_nettype wire

FILE: design/sorted_record_table_unit.sv
// Sorted record table: records kept in ascending key order in one RAM.
// Depends on srt_pkg and srt_ram.
//
//  channel   dir   signals                     word
//  s_*       in    tvalid tready tdata tuser   command: key, scores; tuser = mode
//  m_*       out   tvalid tready tdata tuser   result: key, scores, sum; tuser = status
//                  tlast                       last word of a command
//
// One command at a time. Insert reads and compares records from the top down,
// shifting each larger key up, until it reaches the bottom slot or stops on a
// smaller or equal key; delete scans records from the bottom, then shifts the
// records above the match down; list reads each record and emits it. The pace
// is set by the single RAM read port and its registered read (read, then compare/write).
// Reset clears the record count and the control and output registers; the RAM is never cleared.
// A stalled output holds the sequencer; a new command is taken while the
// last result word still waits on m_tready.
`default_nettype none

module sorted_record_table_unit #(
    parameter int DEPTH = srt_pkg::SRT_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [15:0] record_key, [22:16] first_score, [29:23] second_score
    input  wire logic [srt_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  wire logic [srt_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [15:0] out_key, [22:16] out_first, [29:23] out_second, [37:30] average_halves
    output logic [srt_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [2:0] status
    output logic [srt_pkg::OUT_USER_W-1:0]      m_tuser,
    output logic                                m_tlast
);

    import srt_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_RD,
        S_DEL_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_LST_RD,
        S_LST_OUT,
        S_EMIT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    rec_t              cmd_reg;
    rec_t              res_rec_reg;
    status_t           res_status_reg;
    logic              m_tvalid_reg;
    rec_t              m_rec_reg;
    status_t           m_status_reg;
    logic              m_last_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    rec_t              ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    rec_t              rd_data;
    logic [REC_W-1:0]  rd_bits;

    rec_t              in_rec;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  idx_dec;
    logic              out_free;
    logic              out_load;
    logic              idx_is_last;

    // Incoming word unpacked, sum formed here
    always_comb
    begin
        in_rec.key    = s_tdata[KEY_W-1:0];
        in_rec.first  = s_tdata[KEY_W+SCORE_W-1:KEY_W];
        in_rec.second = s_tdata[KEY_W+2*SCORE_W-1:KEY_W+SCORE_W];
        in_rec.sum    = {1'b0, in_rec.first} + {1'b0, in_rec.second};
    end

    assign idx_inc     = idx_reg + CNT_W'(1);
    assign idx_dec     = idx_reg - CNT_W'(1);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign out_load    = ((state_reg == S_LST_OUT) || (state_reg == S_EMIT)) && out_free;
    assign idx_is_last = (idx_inc >= count_reg);
    assign rd_data     = rec_t'(rd_bits);

    // RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = rd_data;
        ram_re    = 1'b0;
        ram_raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_INS_RD:
            begin
                if (idx_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[AW-1:0];
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = cmd_reg;
                end
            end
            S_INS_CMP:
            begin
                // shift the larger key up, or drop the new record in its slot
                ram_we = 1'b1;
                if (rd_data.key <= cmd_reg.key)
                begin
                    ram_wdata = cmd_reg;
                end
            end
            S_DEL_RD:
            begin
                ram_re = (idx_reg != count_reg);
            end
            S_SHF_RD:
            begin
                ram_re    = !idx_is_last;
                ram_raddr = idx_inc[AW-1:0];
            end
            S_SHF_WR:
            begin
                ram_we = 1'b1;
            end
            S_LST_RD:
            begin
                ram_re = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    srt_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_bits)
    );

    // Command sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            cmd_reg        <= '0;
            res_rec_reg    <= '0;
            res_status_reg <= ST_INSERTED;
            m_tvalid_reg   <= 1'b0;
            m_rec_reg      <= '0;
            m_status_reg   <= ST_INSERTED;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg <= in_rec;
                        idx_reg <= '0;
                        case (mode_t'(s_tuser))
                            MODE_INSERT:
                            begin
                                if (count_reg == CNT_W'(DEPTH))
                                begin
                                    res_rec_reg    <= in_rec;
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_EMIT;
                                end
                                else
                                begin
                                    idx_reg   <= count_reg;
                                    state_reg <= S_INS_RD;
                                end
                            end
                            MODE_DELETE:
                            begin
                                state_reg <= S_DEL_RD;
                            end
                            MODE_LIST:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_rec_reg    <= '0;
                                    res_status_reg <= ST_EMPTY;
                                    state_reg      <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_LST_RD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_INS_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        count_reg      <= count_reg + CNT_W'(1);
                        res_rec_reg    <= cmd_reg;
                        res_status_reg <= ST_INSERTED;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end
                S_INS_CMP:
                begin
                    if (rd_data.key > cmd_reg.key)
                    begin
                        idx_reg   <= idx_dec;
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        count_reg      <= count_reg + CNT_W'(1);
                        res_rec_reg    <= cmd_reg;
                        res_status_reg <= ST_INSERTED;
                        state_reg      <= S_EMIT;
                    end
                end
                S_DEL_RD:
                begin
                    if (idx_reg == count_reg)
                    begin
                        // key only, scores and sum zero
                        res_rec_reg    <= rec_t'(REC_W'(cmd_reg.key));
                        res_status_reg <= ST_NOTFOUND;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_DEL_CMP;
                    end
                end
                S_DEL_CMP:
                begin
                    if (rd_data.key == cmd_reg.key)
                    begin
                        res_rec_reg    <= rd_data;
                        res_status_reg <= ST_DELETED;
                        state_reg      <= S_SHF_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_DEL_RD;
                    end
                end
                S_SHF_RD:
                begin
                    if (idx_is_last)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SHF_WR;
                    end
                end
                S_SHF_WR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_SHF_RD;
                end
                S_LST_RD:
                begin
                    state_reg <= S_LST_OUT;
                end
                S_LST_OUT:
                begin
                    // read data holds while the output stalls
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_rec_reg    <= rd_data;
                        m_status_reg <= ST_LISTED;
                        m_last_reg   <= idx_is_last;
                        if (idx_is_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= S_LST_RD;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_rec_reg    <= res_rec_reg;
                        m_status_reg <= res_status_reg;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - REC_W)'(0), m_rec_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

FILE: design/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/srt_checker.sv
// Port-level checks on the sorted record table results, bound to the top level.
// Depends on srt_pkg and sorted_record_table_unit.
`default_nettype none

module srt_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [srt_pkg::IN_DATA_W-1:0]  s_tdata,
    input wire logic [srt_pkg::IN_USER_W-1:0]  s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [srt_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [srt_pkg::OUT_USER_W-1:0] m_tuser,
    input wire logic                           m_tlast
);

    import srt_pkg::*;

    logic [SCORE_W-1:0] chk_first;
    logic [SCORE_W-1:0] chk_second;
    logic [SUM_W-1:0]   chk_sum;
    logic               chk_in_seen;

    assign chk_first   = m_tdata[KEY_W+SCORE_W-1:KEY_W];
    assign chk_second  = m_tdata[KEY_W+2*SCORE_W-1:KEY_W+SCORE_W];
    assign chk_sum     = m_tdata[KEY_W+2*SCORE_W+SUM_W-1:KEY_W+2*SCORE_W];
    assign chk_in_seen = s_tvalid && s_tready && (s_tdata != '1 || s_tuser != '1);

    // A stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Only single-word commands report anything but a listed entry
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_LISTED |-> m_tlast)
        else $error("single result without last mark");

    // Record-carrying results hold the score sum
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_INSERTED || m_tuser == ST_FULL
            || m_tuser == ST_DELETED || m_tuser == ST_LISTED)
        |-> ({1'b0, chk_sum} == ({2'b0, chk_first} + {2'b0, chk_second})))
        else $error("average_halves is not the score sum");

    // Not found and empty carry zero scores
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_NOTFOUND || m_tuser == ST_EMPTY)
        |-> chk_first == '0 && chk_second == '0 && chk_sum == '0)
        else $error("scores not cleared on not found or empty");

    // Status code in range whenever a result is valid or a command word other than all ones is taken
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid || chk_in_seen |-> m_tuser <= ST_EMPTY)
        else $error("status code out of range");

endmodule

bind sorted_record_table_unit srt_checker u_srt_checker (.*);

`default_nettype wire

FILE: tb/sorted_record_table_unit_test.sv
// Self-checking test of sorted_record_table_unit: insert, delete and list commands
// against a cycle-free table predictor, with random stalls on both streams.
// Depends on srt_pkg and the sorted_record_table_unit RTL.
`default_nettype none

module sorted_record_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srt_pkg::*;

    // mode value the block leaves unused; such a word is dropped silently
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 250;
    localparam int SETTLE_CYCLES = 200;

    // Table predictor plus queue of result words still owed by the block
    class record_table_scoreboard;
        typedef struct {
            status_t status;
            rec_t    rec;
            logic    last;
        } result_word_t;

        rec_t         slots[SRT_DEPTH];
        int unsigned  count;
        result_word_t expected_words[$];
        int unsigned  error_count;

        function new();
            count = 0;
            error_count = 0;
        endfunction

        function void push_word(status_t status, rec_t rec, logic last);
            result_word_t w;
            w.status = status;
            w.rec = rec;
            w.last = last;
            expected_words.push_back(w);
        endfunction

        // Apply one accepted command word to the table copy
        function void note_command(logic [1:0] mode, rec_t offered);
            rec_t        blank;
            rec_t        gone;
            int unsigned pos;
            int unsigned i;
            blank = '0;
            offered.sum = {1'b0, offered.first} + {1'b0, offered.second};
            case (mode)
                MODE_INSERT:
                begin
                    if (count >= SRT_DEPTH) begin
                        push_word(ST_FULL, offered, 1'b1);
                    end
                    else begin
                        // equal keys stay in arrival order
                        pos = 0;
                        while (pos < count && slots[pos].key <= offered.key) pos++;
                        for (i = count; i > pos; i--) slots[i] = slots[i-1];
                        slots[pos] = offered;
                        count++;
                        push_word(ST_INSERTED, offered, 1'b1);
                    end
                end
                MODE_DELETE:
                begin
                    pos = 0;
                    while (pos < count && slots[pos].key != offered.key) pos++;
                    if (pos < count) begin
                        gone = slots[pos];
                        for (i = pos; i + 1 < count; i++) slots[i] = slots[i+1];
                        count--;
                        push_word(ST_DELETED, gone, 1'b1);
                    end
                    else begin
                        blank.key = offered.key;
                        push_word(ST_NOTFOUND, blank, 1'b1);
                    end
                end
                MODE_LIST:
                begin
                    if (count == 0) begin
                        push_word(ST_EMPTY, blank, 1'b1);
                    end
                    else begin
                        for (i = 0; i < count; i++)
                            push_word(ST_LISTED, slots[i], (i + 1 == count));
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void check_word(logic [2:0] status, rec_t got, logic last);
            result_word_t want;
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: status %0d key %0h",
                       status, got.key);
                error_count++;
                return;
            end
            want = expected_words.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                error_count++;
            end
            if (got.key !== want.rec.key) begin
                $error("out_key: expected %0h, actual %0h", want.rec.key, got.key);
                error_count++;
            end
            if (got.first !== want.rec.first) begin
                $error("out_first: expected %0d, actual %0d", want.rec.first, got.first);
                error_count++;
            end
            if (got.second !== want.rec.second) begin
                $error("out_second: expected %0d, actual %0d",
                       want.rec.second, got.second);
                error_count++;
            end
            if (got.sum !== want.rec.sum) begin
                $error("average_halves: expected %0d, actual %0d", want.rec.sum, got.sum);
                error_count++;
            end
            if (last !== want.last) begin
                $error("last_flag: expected %0b, actual %0b", want.last, last);
                error_count++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [IN_USER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   m_tlast;

    record_table_scoreboard sb = new();
    int unsigned            burst_left = 4;
    int unsigned            rx_cycle = 0;

    sorted_record_table_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Send one command word; after each burst the valid drops for a random gap
    task automatic send_command(input logic [1:0] mode, input logic [15:0] key,
                                input logic [6:0] first, input logic [6:0] second);
        rec_t        offered;
        int unsigned gap_len;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, second, first, key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        offered = '0;
        offered.key = key;
        offered.first = first;
        offered.second = second;
        sb.note_command(mode, offered);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap_len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25)
                                                  : $urandom_range(1, 4);
            repeat (gap_len) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    // Hold the sender off until the block owes nothing
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.expected_words.size() != 0) @(posedge clk);
        burst_left = $urandom_range(1, 12);
    endtask

    // Receiver: the stall pattern steps through four patterns in turn; results are checked here
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tuser, rec_t'(m_tdata[REC_W-1:0]), m_tlast);
            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle / 150) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 5) == 0);
                default: m_tready <= ((rx_cycle % 16) < 10);
            endcase
        end
    end

    // Stimulus
    initial begin
        int unsigned phase;
        int unsigned roll;
        int unsigned insert_cut;
        int unsigned delete_cut;
        logic [15:0] key;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table cases first
        send_command(MODE_LIST,   16'h0000, 7'd0, 7'd0);
        send_command(MODE_DELETE, 16'h0005, 7'd0, 7'd0);
        send_command(MODE_UNUSED, 16'hFFFF, 7'd100, 7'd100);
        // extremes of key and scores, equal keys in arrival order
        send_command(MODE_INSERT, 16'h8000, 7'd100, 7'd100);
        send_command(MODE_INSERT, 16'h0000, 7'd0,   7'd0);
        send_command(MODE_INSERT, 16'hFFFF, 7'd100, 7'd0);
        send_command(MODE_INSERT, 16'h8000, 7'd1,   7'd2);
        send_command(MODE_INSERT, 16'h8000, 7'd64,  7'd63);
        send_command(MODE_INSERT, 16'h7FFF, 7'd27,  7'd99);
        send_command(MODE_LIST,   16'h0000, 7'd0,   7'd0);
        // unused mode must leave the table alone
        send_command(MODE_UNUSED, 16'h8000, 7'd5,   7'd5);
        // delete takes the oldest of the equal keys
        send_command(MODE_DELETE, 16'h8000, 7'd0,   7'd0);
        send_command(MODE_DELETE, 16'h1234, 7'd0,   7'd0);
        send_command(MODE_DELETE, 16'hFFFF, 7'd0,   7'd0);
        send_command(MODE_DELETE, 16'h0000, 7'd0,   7'd0);
        send_command(MODE_LIST,   16'h0000, 7'd0,   7'd0);
        send_command(MODE_INSERT, 16'h5555, 7'd85,  7'd42);
        send_command(MODE_INSERT, 16'hAAAA, 7'd42,  7'd85);
        send_command(MODE_LIST,   16'h0000, 7'd0,   7'd0);
        wait_for_results();

        // random: phases that grow the table to full, shrink it, and mix
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            phase = (n / 64) % 4;
            case (phase)
                1:       begin insert_cut = 20; delete_cut = 85; end
                2:       begin insert_cut = 45; delete_cut = 80; end
                default: begin insert_cut = 80; delete_cut = 88; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < insert_cut) begin
                // narrow keys give duplicates, wide keys reach every bit
                case ($urandom_range(0, 7))
                    0:       key = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                    1, 2:    key = 16'($urandom_range(0, 16'hFFFF));
                    3:       key = (sb.count != 0) ? sb.slots[$urandom_range(0, sb.count-1)].key
                                                   : 16'h0000;
                    default: key = 16'($urandom_range(0, 15));
                endcase
                send_command(MODE_INSERT, key,
                             ($urandom_range(0, 7) == 0) ? 7'd100 : 7'($urandom_range(0, 100)),
                             ($urandom_range(0, 7) == 0) ? 7'd0   : 7'($urandom_range(0, 100)));
            end
            else if (roll < delete_cut) begin
                if (sb.count != 0 && $urandom_range(0, 9) < 7)
                    key = sb.slots[$urandom_range(0, sb.count-1)].key;
                else
                    key = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 15))
                                                      : 16'($urandom_range(0, 16'hFFFF));
                send_command(MODE_DELETE, key, 7'($urandom_range(0, 100)),
                             7'($urandom_range(0, 100)));
            end
            else if (roll < 96) begin
                send_command(MODE_LIST, 16'($urandom_range(0, 16'hFFFF)),
                             7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)));
            end
            else begin
                send_command(MODE_UNUSED, 16'($urandom_range(0, 16'hFFFF)),
                             7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)));
            end
            if (n % 100 == 99)
                wait_for_results();
        end

        // drain, then give a stray word time to show up
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
            $display("sorted_record_table_unit_test: PASS");
        else
            $display("sorted_record_table_unit_test: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("sorted_record_table_unit_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sorted_record_table_unit.f
design/srt_pkg.sv
design/srt_ram.sv
design/sorted_record_table_unit.sv
design/srt_checker.sv
tb/sorted_record_table_unit_test.sv
